FILE: rtl/core/rspe_pkg.sv
package rspe_pkg;

    // Field polynomial x^8 + x^4 + x^3 + x^2 + 1, and the generator roots are
    // successive powers of alpha = 2.
    localparam logic [8:0] FIELD_POLY = 9'h11D;

    localparam int RSPE_MAX_PARITY   = 30;
    localparam int RSPE_QUEUE_DEPTH  = 2;
    localparam logic [4:0] RSPE_PARITY_COUNT_RESET = 5'd10;

    // One queued data beat.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } rspe_item_t;

    // Multiply by alpha in GF(256).
    function automatic logic [7:0] gf_xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? FIELD_POLY[7:0] : 8'h00);
    endfunction

    // General GF(256) product, shift and add over the bits of b.
    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] acc;
        x   = a;
        acc = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                acc = acc ^ x;
            end
            x = gf_xtime(x);
        end
        return acc;
    endfunction

endpackage

FILE: rtl/core/reed_solomon_parity_encoder_unit.sv
// Systematic Reed-Solomon parity encoder over GF(256), field polynomial 0x11D.
// Data channel: one data_byte per beat (data_valid/data_stall); last_data marks
// the final byte of a block. Parity channel: after the last beat the block
// returns parity_count parity bytes, highest degree first, with last_parity on
// the final one (parity_valid/parity_stall).
// Config channel: cfg_valid/cfg_ready writes parity_count (0 acts as 1, values
// above MAX_PARITY act as MAX_PARITY). Write it only while no block is open.
// After reset or a write the generator polynomial is rebuilt, one root per
// cycle, and data_stall and !cfg_ready hold until all n roots are in (n is 10
// after reset). Throughput: one data beat per cycle while data_stall is low;
// the remainder shift register updates all taps at once. A two-entry queue
// sits in front of it. The last data beat passes through the queue, and its
// pop loads an unload register, which then offers the first parity beat. The
// parity bytes drain from it one per cycle while parity_stall is low, and the
// next block's data keep flowing into the remainder. A second last_data waits
// only if the previous parity is still draining. When parity_stall is high the
// current parity beat holds; a last_data beat at the queue head then waits,
// the queue fills, and data_stall rises.
module reed_solomon_parity_encoder_unit
    import rspe_pkg::*;
#(
    parameter int MAX_PARITY  = RSPE_MAX_PARITY,
    parameter int QUEUE_DEPTH = RSPE_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_data,
    output logic        parity_valid,
    input  logic        parity_stall,
    output logic [7:0]  parity_byte,
    output logic        last_parity,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  parity_count
);

    localparam int NW = $clog2(MAX_PARITY + 1);

    logic [MAX_PARITY:0][7:0]   gen;
    logic [NW-1:0]              n;
    logic                       gen_busy;
    logic                       q_valid;
    logic                       q_pop;
    rspe_item_t                 q_item;

    // Generator builder and parity count register.
    rspe_gen #(
        .MAX_PARITY (MAX_PARITY)
    ) u_gen (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .parity_count (parity_count),
        .gen          (gen),
        .n            (n),
        .busy         (gen_busy)
    );

    // Front: accepts data beats into a short queue.
    rspe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold       (gen_busy),
        .data_valid (data_valid),
        .data_stall (data_stall),
        .data_byte  (data_byte),
        .last_data  (last_data),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    // Back: remainder register and parity unload.
    rspe_back #(
        .MAX_PARITY (MAX_PARITY)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .gen          (gen),
        .n            (n),
        .parity_valid (parity_valid),
        .parity_stall (parity_stall),
        .parity_byte  (parity_byte),
        .last_parity  (last_parity)
    );

endmodule

FILE: rtl/core/rspe_gen.sv
module rspe_gen
    import rspe_pkg::*;
#(
    parameter int MAX_PARITY = RSPE_MAX_PARITY,
    localparam int NW = $clog2(MAX_PARITY + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [4:0]                  parity_count,
    output logic [MAX_PARITY:0][7:0]    gen,
    output logic [NW-1:0]               n,
    output logic                        busy
);

    localparam logic [7:0] MAX8 = 8'(MAX_PARITY);

    logic [4:0]                 pc_reg;
    logic [NW-1:0]              step_reg;
    logic [MAX_PARITY:0][7:0]   gen_reg;
    logic [MAX_PARITY:0][7:0]   gen_next;
    logic [7:0]                 root_reg;
    logic [7:0]                 pc8;
    logic [7:0]                 n8;
    logic                       cfg_fire;

    // Active count: zero acts as one, anything above the maximum is clamped.
    always_comb
    begin
        pc8 = {3'b000, pc_reg};
        if (pc8 == 8'd0)
        begin
            n8 = 8'd1;
        end
        else if (pc8 > MAX8)
        begin
            n8 = MAX8;
        end
        else
        begin
            n8 = pc8;
        end
    end

    assign n         = n8[NW-1:0];
    assign busy      = (step_reg != n);
    assign cfg_ready = !busy;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign gen       = gen_reg;

    // One root factor (x + root) is multiplied in per cycle.
    always_comb
    begin
        gen_next[0] = gen_reg[0];
        for (int j = 1; j <= MAX_PARITY; j++)
        begin
            gen_next[j] = gen_reg[j] ^ gf_mul(gen_reg[j-1], root_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= RSPE_PARITY_COUNT_RESET;
            step_reg <= '0;
            gen_reg  <= {{MAX_PARITY{8'h00}}, 8'h01};
            root_reg <= 8'h01;
        end
        else if (cfg_fire)
        begin
            pc_reg   <= parity_count;
            step_reg <= '0;
            gen_reg  <= {{MAX_PARITY{8'h00}}, 8'h01};
            root_reg <= 8'h01;
        end
        else if (busy)
        begin
            step_reg <= step_reg + NW'(1);
            gen_reg  <= gen_next;
            root_reg <= gf_xtime(root_reg);
        end
    end

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> step_reg < n)
        else $error("generator step ran past the parity count");
`endif

endmodule

FILE: rtl/core/rspe_queue.sv
module rspe_queue
    import rspe_pkg::*;
#(
    parameter int DEPTH = RSPE_QUEUE_DEPTH,
    localparam int PW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        hold,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_data,
    output logic        q_valid,
    output rspe_item_t  q_item,
    input  logic        q_pop
);

    rspe_item_t     mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           push;

    // The front holds off while the generator is being rebuilt.
    assign data_stall = (count_reg == CW'(DEPTH)) || hold;
    assign push       = data_valid && !data_stall;
    assign q_valid    = (count_reg != '0);
    assign q_item     = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= '{data: data_byte, last: last_data};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (q_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (q_pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

FILE: rtl/core/rspe_back.sv
module rspe_back
    import rspe_pkg::*;
#(
    parameter int MAX_PARITY = RSPE_MAX_PARITY,
    localparam int NW = $clog2(MAX_PARITY + 1)
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  rspe_item_t                  q_item,
    output logic                        q_pop,
    input  logic [MAX_PARITY:0][7:0]    gen,
    input  logic [NW-1:0]               n,
    output logic                        parity_valid,
    input  logic                        parity_stall,
    output logic [7:0]                  parity_byte,
    output logic                        last_parity
);

    logic [MAX_PARITY-1:0][7:0] rem_reg;
    logic [MAX_PARITY-1:0][7:0] rem_next;
    logic [MAX_PARITY-1:0][7:0] par_reg;
    logic [NW-1:0]              cnt_reg;
    logic [7:0]                 fb;
    logic                       out_fire;
    logic                       unload_free;
    logic                       load;

    assign fb = q_item.data ^ rem_reg[0];

    // Remainder update: only the first n entries shift, the rest stay put.
    always_comb
    begin
        for (int i = 0; i < MAX_PARITY - 1; i++)
        begin
            if (NW'(i + 1) < n)
            begin
                rem_next[i] = rem_reg[i+1] ^ gf_mul(fb, gen[i+1]);
            end
            else if (NW'(i + 1) == n)
            begin
                rem_next[i] = gf_mul(fb, gen[i+1]);
            end
            else
            begin
                rem_next[i] = rem_reg[i];
            end
        end
        if (n == NW'(MAX_PARITY))
        begin
            rem_next[MAX_PARITY-1] = gf_mul(fb, gen[MAX_PARITY]);
        end
        else
        begin
            rem_next[MAX_PARITY-1] = rem_reg[MAX_PARITY-1];
        end
    end

    assign parity_valid = (cnt_reg != '0);
    assign parity_byte  = par_reg[0];
    assign last_parity  = (cnt_reg == NW'(1));
    assign out_fire     = parity_valid && !parity_stall;
    assign unload_free  = (cnt_reg == '0) || ((cnt_reg == NW'(1)) && out_fire);
    assign q_pop        = q_valid && (!q_item.last || unload_free);
    assign load         = q_pop && q_item.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                rem_reg <= q_item.last ? '0 : rem_next;
            end
            if (load)
            begin
                cnt_reg <= n;
            end
            else if (out_fire)
            begin
                cnt_reg <= cnt_reg - NW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            par_reg <= rem_next;
        end
        else if (out_fire)
        begin
            par_reg <= par_reg >> 8;
        end
    end

`ifndef SYNTHESIS
    a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> cnt_reg == $past(n))
        else $error("unload count does not match the parity count");

    a_rem_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> rem_reg == '0)
        else $error("remainder not cleared after the last data beat");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (cnt_reg == '0) || ((cnt_reg == NW'(1)) && out_fire))
        else $error("parity unload overwritten before it drained");
`endif

endmodule
